// ===== hdl/bxavg_pkg.sv =====
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared widths, register indexes, divider operation codes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bxavg_pkg;

   localparam int REG_W      = 11;              // size registers and positions
   localparam int PIX_W      = 16;
   localparam int F_W        = 12;              // scale factor and in-block counters
   localparam int FSQ_W      = 2 * F_W;         // factor squared
   localparam int SUM_W      = FSQ_W + PIX_W;   // exact block sum
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_ROWS_DEFAULT = 1024;
   localparam int MAX_COLS_DEFAULT = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ROWS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_KIND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_MASK    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AND_MODE    = 3'd6;

   // what the shared divider is working on
   typedef enum logic [2:0] {
      DIV_QR,    // rows / target_rows
      DIV_QC,    // cols / target_cols
      DIV_RF,    // rows / factor, first check
      DIV_CF,    // cols / factor, second check
      DIV_NR,    // output rows
      DIV_NC,    // output cols
      DIV_AVG    // block sum / factor squared
   } div_op_type;

   typedef struct packed {
      logic       capture;
      logic       wrap;
      logic       frame_init;
      logic       div_start;
      logic       div_store;
      div_op_type div_op;
      logic       accumulate;
      logic       rsp_load;
      logic       advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_start;
      logic dims_dirty;
      logic div_done;
      logic in_region;
      logic block_last;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/bxavg_div.sv =====
// ----------------------------------------------------------------------------
// bxavg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bxavg_div #(
   parameter int N = bxavg_pkg::SUM_W,
   parameter int D = bxavg_pkg::FSQ_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [N-1:0] dividend,
   input  wire logic [D-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [N-1:0]      quotient
);

   localparam int CNT_W = $clog2(N + 1);

   logic [D-1:0]     rem_ff, rem_in;
   logic [N-1:0]     quo_ff, quo_in;
   logic [D-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D:0]       trial;
   logic [D:0]       diff;

   assign trial = {rem_ff, quo_ff[N-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[D]) begin
            rem_in = diff[D-1:0];
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = trial[D-1:0];
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/bxavg_datapath.sv =====
// ----------------------------------------------------------------------------
// bxavg_datapath
// Configuration registers, raster position counters, column sum line store,
// factor derivation through the shared divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bxavg_datapath #(
   parameter int MAX_ROWS = bxavg_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = bxavg_pkg::MAX_COLS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bxavg_pkg::ctrl_cmd_type               cmd,
   output bxavg_pkg::dp_status_type                   status,
   input  wire logic                                  req_valid,
   input  wire logic signed [bxavg_pkg::PIX_W-1:0]    req_pixel,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic signed [bxavg_pkg::PIX_W-1:0]         rsp_avg_pixel,
   output logic [bxavg_pkg::REG_W-1:0]                rsp_out_rows,
   output logic [bxavg_pkg::REG_W-1:0]                rsp_out_cols,
   output logic                                       rsp_frame_end,
   input  wire logic                                  csr_we,
   input  wire logic [bxavg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bxavg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int REG_W = bxavg_pkg::REG_W;
   localparam int PIX_W = bxavg_pkg::PIX_W;
   localparam int F_W   = bxavg_pkg::F_W;
   localparam int FSQ_W = bxavg_pkg::FSQ_W;
   localparam int SUM_W = bxavg_pkg::SUM_W;
   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   // configuration
   logic [REG_W-1:0] image_rows_ff, image_cols_ff, target_rows_ff, target_cols_ff;
   logic             pixel_kind_ff, and_mode_ff;
   logic [PIX_W-1:0] bit_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff  <= REG_W'(1024);
         image_cols_ff  <= REG_W'(1024);
         target_rows_ff <= REG_W'(256);
         target_cols_ff <= REG_W'(256);
         pixel_kind_ff  <= 1'b0;
         bit_mask_ff    <= '0;
         and_mode_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            bxavg_pkg::CSR_IMAGE_ROWS:  image_rows_ff  <= csr_wdata[REG_W-1:0];
            bxavg_pkg::CSR_IMAGE_COLS:  image_cols_ff  <= csr_wdata[REG_W-1:0];
            bxavg_pkg::CSR_TARGET_ROWS: target_rows_ff <= csr_wdata[REG_W-1:0];
            bxavg_pkg::CSR_TARGET_COLS: target_cols_ff <= csr_wdata[REG_W-1:0];
            bxavg_pkg::CSR_PIXEL_KIND:  pixel_kind_ff  <= csr_wdata[0];
            bxavg_pkg::CSR_BIT_MASK:    bit_mask_ff    <= csr_wdata[PIX_W-1:0];
            bxavg_pkg::CSR_AND_MODE:    and_mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [REG_W-1:0] rows_eff, cols_eff, tr_eff, tc_eff;

   always_comb begin
      if (image_rows_ff == '0)                    rows_eff = REG_W'(1);
      else if (32'(image_rows_ff) > MAX_ROWS)     rows_eff = REG_W'(MAX_ROWS);
      else                                        rows_eff = image_rows_ff;
      if (image_cols_ff == '0)                    cols_eff = REG_W'(1);
      else if (32'(image_cols_ff) > MAX_COLS)     cols_eff = REG_W'(MAX_COLS);
      else                                        cols_eff = image_cols_ff;
      tr_eff = (target_rows_ff == '0) ? REG_W'(1) : target_rows_ff;
      tc_eff = (target_cols_ff == '0) ? REG_W'(1) : target_cols_ff;
   end

   // pixel preparation at the input transfer
   logic [PIX_W-1:0]        pix_prep;
   logic signed [PIX_W-1:0] pix_ff;

   always_comb begin
      pix_prep = req_pixel;
      if (pixel_kind_ff) begin
         pix_prep = {8'd0, req_pixel[7:0]};
      end else if (bit_mask_ff != '0) begin
         if (and_mode_ff)
            pix_prep = req_pixel & bit_mask_ff;
         else if ((req_pixel & bit_mask_ff) != '0)
            pix_prep = req_pixel | bit_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_valid)
         pix_ff <= pix_prep;
   end

   // factor state
   logic [F_W-1:0]   f_ff, f_in;
   logic [F_W-1:0]   qtmp_ff, qtmp_in;
   logic [FSQ_W-1:0] fsq_ff;
   logic [REG_W-1:0] nrows_ff, nrows_in, ncols_ff, ncols_in;
   logic             dirty_ff, dirty_in;
   logic signed [PIX_W-1:0] avg_ff, avg_in;

   // position counters
   logic [REG_W-1:0] col_ff, row_ff, bcol_ff, brow_ff;
   logic [REG_W-1:0] col_in, row_in, bcol_in, brow_in;
   logic [F_W-1:0]   cib_ff, rib_ff, cib_in, rib_in;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bcol_in = bcol_ff;
      brow_in = brow_ff;
      cib_in  = cib_ff;
      rib_in  = rib_ff;
      if (cmd.advance) begin
         col_in = col_ff + 1'b1;
         cib_in = cib_ff + 1'b1;
         if (cib_in >= f_ff) begin
            cib_in  = '0;
            bcol_in = bcol_ff + 1'b1;
         end
      end
      // end of row, then end of frame
      if (col_in >= cols_eff) begin
         col_in  = '0;
         cib_in  = '0;
         bcol_in = '0;
         row_in  = row_in + 1'b1;
         rib_in  = rib_in + 1'b1;
         if (rib_in >= f_ff) begin
            rib_in  = '0;
            brow_in = brow_in + 1'b1;
         end
      end
      if (row_in >= rows_eff) begin
         row_in  = '0;
         rib_in  = '0;
         brow_in = '0;
      end
      if (cmd.frame_init) begin
         cib_in  = '0;
         rib_in  = '0;
         bcol_in = '0;
         brow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bcol_ff <= '0;
         brow_ff <= '0;
         cib_ff  <= '0;
         rib_ff  <= '0;
      end else if (cmd.wrap || cmd.advance || cmd.frame_init) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bcol_ff <= bcol_in;
         brow_ff <= brow_in;
         cib_ff  <= cib_in;
         rib_ff  <= rib_in;
      end
   end

   // column sum line store
   logic signed [SUM_W-1:0] mem [MAX_COLS];
   logic signed [SUM_W-1:0] rd_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_new;
   logic [IDX_W-1:0]        idx;
   logic                    in_region, block_last, mem_we, fe_ff;

   assign idx        = IDX_W'(bcol_ff);
   assign in_region  = (brow_ff < nrows_ff) && (bcol_ff < ncols_ff) &&
                       (32'(bcol_ff) < MAX_COLS);
   assign block_last = (rib_ff == f_ff - 1'b1) && (cib_ff == f_ff - 1'b1);
   assign sum_new    = (rib_ff == '0 && cib_ff == '0) ? SUM_W'(pix_ff)
                                                      : rd_ff + SUM_W'(pix_ff);
   assign mem_we     = cmd.accumulate && in_region;

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[idx] <= sum_new;
      rd_ff <= mem[idx];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_ff <= sum_new;
         fe_ff  <= (brow_ff == nrows_ff - 1'b1) && (bcol_ff == ncols_ff - 1'b1);
      end
   end

   // shared divider
   logic [SUM_W-1:0] dvd, quo, sum_mag;
   logic [FSQ_W-1:0] dsr;
   logic             div_busy, div_done;

   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      case (cmd.div_op)
         bxavg_pkg::DIV_QR: begin
            dvd = SUM_W'(rows_eff);
            dsr = FSQ_W'(tr_eff);
         end
         bxavg_pkg::DIV_QC: begin
            dvd = SUM_W'(cols_eff);
            dsr = FSQ_W'(tc_eff);
         end
         bxavg_pkg::DIV_RF, bxavg_pkg::DIV_NR: begin
            dvd = SUM_W'(rows_eff);
            dsr = FSQ_W'(f_ff);
         end
         bxavg_pkg::DIV_CF, bxavg_pkg::DIV_NC: begin
            dvd = SUM_W'(cols_eff);
            dsr = FSQ_W'(f_ff);
         end
         bxavg_pkg::DIV_AVG: begin
            dvd = sum_mag;
            dsr = fsq_ff;
         end
         default: begin
            dvd = sum_mag;
            dsr = fsq_ff;
         end
      endcase
   end

   bxavg_div #(
      .N (SUM_W),
      .D (FSQ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quo)
   );

   // results of the divider
   logic [F_W-1:0] q_f, qc_f;

   assign q_f  = F_W'(quo);
   assign qc_f = (quo == '0) ? F_W'(1) : q_f;

   always_comb begin
      f_in     = f_ff;
      qtmp_in  = qtmp_ff;
      nrows_in = nrows_ff;
      ncols_in = ncols_ff;
      avg_in   = avg_ff;
      dirty_in = dirty_ff;
      if (cmd.div_store) begin
         case (cmd.div_op)
            bxavg_pkg::DIV_QR: qtmp_in = qc_f;
            bxavg_pkg::DIV_QC: f_in = (qtmp_ff > qc_f) ? qtmp_ff : qc_f;
            bxavg_pkg::DIV_RF: if (quo > SUM_W'(tr_eff)) f_in = f_ff + 1'b1;
            bxavg_pkg::DIV_CF: if (quo > SUM_W'(tc_eff)) f_in = f_ff + 1'b1;
            bxavg_pkg::DIV_NR: nrows_in = REG_W'(quo);
            bxavg_pkg::DIV_NC: begin
               ncols_in = REG_W'(quo);
               dirty_in = 1'b0;
            end
            bxavg_pkg::DIV_AVG: avg_in = sum_ff[SUM_W-1] ? PIX_W'(-quo) : PIX_W'(quo);
            default: ;
         endcase
      end
      // a size change must reach the block counts before the next pixel
      if (csr_we && (csr_index == bxavg_pkg::CSR_IMAGE_ROWS ||
                     csr_index == bxavg_pkg::CSR_IMAGE_COLS))
         dirty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      qtmp_ff  <= qtmp_in;
      nrows_ff <= nrows_in;
      ncols_ff <= ncols_in;
      avg_ff   <= avg_in;
      fsq_ff   <= FSQ_W'(f_ff) * FSQ_W'(f_ff);
      if (reset) begin
         f_ff     <= F_W'(1);
         dirty_ff <= 1'b1;
      end else begin
         f_ff     <= f_in;
         dirty_ff <= dirty_in;
      end
   end

   // result register
   logic                    rsp_valid_ff;
   logic signed [PIX_W-1:0] rsp_avg_ff;
   logic [REG_W-1:0]        rsp_rows_ff, rsp_cols_ff;
   logic                    rsp_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_avg_ff  <= avg_ff;
         rsp_rows_ff <= nrows_ff;
         rsp_cols_ff <= ncols_ff;
         rsp_fe_ff   <= fe_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_avg_pixel = rsp_avg_ff;
   assign rsp_out_rows  = rsp_rows_ff;
   assign rsp_out_cols  = rsp_cols_ff;
   assign rsp_frame_end = rsp_fe_ff;

   assign status.frame_start = (row_ff == '0) && (col_ff == '0);
   assign status.dims_dirty  = dirty_ff;
   assign status.div_done    = div_done;
   assign status.in_region   = in_region;
   assign status.block_last  = block_last;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

   a_store_on_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> div_done)
      else $error("divider result taken before done");

   a_factor_nonzero: assert property (@(posedge clock) disable iff (reset)
      f_ff != '0)
      else $error("scale factor is zero");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(bcol_ff) < MAX_COLS))
      else $error("line store write out of range");

endmodule

`default_nettype wire

// ===== hdl/bxavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// bxavg_ctrl
// Sequencer for one pixel: position wrap, factor or size refresh,
// line store read-modify-write, block average division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bxavg_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire bxavg_pkg::dp_status_type  status,
   output bxavg_pkg::ctrl_cmd_type        cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRAP,
      S_CHECK,
      S_DSTART,
      S_DWAIT,
      S_READ,
      S_UPDATE,
      S_OUT,
      S_ADV
   } state_type;

   state_type             state_ff;
   bxavg_pkg::div_op_type op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= bxavg_pkg::DIV_QR;
      end else begin
         case (state_ff)
            S_IDLE:   if (req_valid) state_ff <= S_WRAP;
            S_WRAP:   state_ff <= S_CHECK;
            S_CHECK: begin
               if (status.frame_start) begin
                  op_ff    <= bxavg_pkg::DIV_QR;
                  state_ff <= S_DSTART;
               end else if (status.dims_dirty) begin
                  op_ff    <= bxavg_pkg::DIV_NR;
                  state_ff <= S_DSTART;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_DSTART: state_ff <= S_DWAIT;
            S_DWAIT: begin
               if (status.div_done) begin
                  case (op_ff)
                     bxavg_pkg::DIV_QR: begin
                        op_ff    <= bxavg_pkg::DIV_QC;
                        state_ff <= S_DSTART;
                     end
                     bxavg_pkg::DIV_QC: begin
                        op_ff    <= bxavg_pkg::DIV_RF;
                        state_ff <= S_DSTART;
                     end
                     bxavg_pkg::DIV_RF: begin
                        op_ff    <= bxavg_pkg::DIV_CF;
                        state_ff <= S_DSTART;
                     end
                     bxavg_pkg::DIV_CF: begin
                        op_ff    <= bxavg_pkg::DIV_NR;
                        state_ff <= S_DSTART;
                     end
                     bxavg_pkg::DIV_NR: begin
                        op_ff    <= bxavg_pkg::DIV_NC;
                        state_ff <= S_DSTART;
                     end
                     bxavg_pkg::DIV_NC:  state_ff <= S_READ;
                     bxavg_pkg::DIV_AVG: state_ff <= S_OUT;
                     default:            state_ff <= S_IDLE;
                  endcase
               end
            end
            S_READ:   state_ff <= S_UPDATE;
            S_UPDATE: begin
               if (status.in_region && status.block_last) begin
                  op_ff    <= bxavg_pkg::DIV_AVG;
                  state_ff <= S_DSTART;
               end else begin
                  state_ff <= S_ADV;
               end
            end
            S_OUT:    if (status.rsp_free) state_ff <= S_ADV;
            S_ADV:    state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.div_op     = op_ff;
      cmd.capture    = (state_ff == S_IDLE);
      cmd.wrap       = (state_ff == S_WRAP);
      cmd.frame_init = (state_ff == S_CHECK) && status.frame_start;
      cmd.div_start  = (state_ff == S_DSTART);
      cmd.div_store  = (state_ff == S_DWAIT) && status.div_done;
      cmd.accumulate = (state_ff == S_UPDATE);
      cmd.rsp_load   = (state_ff == S_OUT) && status.rsp_free;
      cmd.advance    = (state_ff == S_ADV);
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/box_average_image_downscale.sv =====
// ----------------------------------------------------------------------------
// box_average_image_downscale
// Box-filter integer decimation of a raster-order image.
// ----------------------------------------------------------------------------
// usage:
//  - pixels enter on req_valid/req_ready in raster order, one transfer each;
//    block averages leave on rsp_valid/rsp_ready with the output size and a
//    frame_end flag on the frame's last average
//  - csr_we writes csr_wdata into register csr_index in the same cycle;
//    write only between pixels
//  - a pixel that produces no average passes the wrap, check, read, update
//    and advance states between its transfer and the next; a pixel that
//    closes a block adds one pass of the bit-serial divider for sum / factor
//    squared and the load of the output register
//  - the first pixel of a frame, or the first after an image size register
//    write, also runs the factor and block count divisions on the same
//    divider: 6 divisions at frame start, 2 after a size change
//  - the line store of column sums has one port, read then written per pixel
//  - an average waits in the output register while rsp_ready is low; the
//    next pixel is still taken and only stalls if it closes another block
//  - reset sets the registers to their defaults and restarts at row 0,
//    column 0; the line store is not cleared, the first row of every band
//    overwrites its entries
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_image_downscale #(
   parameter int MAX_ROWS = bxavg_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = bxavg_pkg::MAX_COLS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [bxavg_pkg::PIX_W-1:0]  req_pixel,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [bxavg_pkg::PIX_W-1:0]       rsp_avg_pixel,
   output logic [bxavg_pkg::REG_W-1:0]              rsp_out_rows,
   output logic [bxavg_pkg::REG_W-1:0]              rsp_out_cols,
   output logic                                     rsp_frame_end,
   input  wire logic                                csr_we,
   input  wire logic [bxavg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bxavg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   bxavg_pkg::ctrl_cmd_type  cmd;
   bxavg_pkg::dp_status_type status;

   bxavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bxavg_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_valid     (req_valid),
      .req_pixel     (req_pixel),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_avg_pixel (rsp_avg_pixel),
      .rsp_out_rows  (rsp_out_rows),
      .rsp_out_cols  (rsp_out_cols),
      .rsp_frame_end (rsp_frame_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the box-average downscaler. It runs a directed
// table of corner frames, then random frame sizes, pixel kinds and masks.
// Every accepted pixel goes through a bench-side box filter, and each block
// average is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic PIX_SIGNED16 = 1'b0;
   localparam logic PIX_UNSIGNED8 = 1'b1;
   localparam logic MASK_OR = 1'b0;
   localparam logic MASK_AND = 1'b1;
   localparam int SETTLE_CYCLES = 350;
   localparam int TARGET_ITEMS = 1050;

   typedef struct packed {
      logic signed [15:0] avg_pixel;
      logic [10:0]        out_rows;
      logic [10:0]        out_cols;
      logic               frame_end;
   } block_avg_type;

   typedef struct {
      bit            is_csr;
      bit            typed;
      logic [2:0]    idx;
      logic [15:0]   value;
      block_avg_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_pixel = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_avg_pixel;
   logic [10:0] rsp_out_rows, rsp_out_cols;
   logic rsp_frame_end;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   box_average_image_downscale i_dut (.*);

   always #5 clock = ~clock;

   // bench copy of registers and frame state
   logic [10:0] m_rows, m_cols, m_trows, m_tcols;
   logic m_kind, m_and;
   logic [15:0] m_mask;
   longint col_sum [1024];
   int unsigned factor, row_pos, col_pos, band_row, block_col;

   block_avg_type pending_avgs[$];
   int errors = 0, items = 0, results = 0, phases = 0;
   bit quiet = 0, hold_rsp = 0;

   function automatic int unsigned size_clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void regs_reset();
      m_rows = 11'd1024; m_cols = 11'd1024; m_trows = 11'd256; m_tcols = 11'd256;
      m_kind = PIX_SIGNED16; m_mask = '0; m_and = MASK_OR;
      factor = 1; row_pos = 0; col_pos = 0; band_row = 0; block_col = 0;
   endfunction

   // returns 1 when this pixel closes a block
   function automatic bit box_filter(logic [15:0] raw, output block_avg_type avg);
      int unsigned rows, cols, tr, tc, nr, nc, br, bc;
      logic [15:0] p;
      longint v;
      bit hit;
      rows = size_clamp(32'(m_rows), 1024);
      cols = size_clamp(32'(m_cols), 1024);
      tr = size_clamp(32'(m_trows), 2047);
      tc = size_clamp(32'(m_tcols), 2047);
      hit = 0;
      avg = '0;
      if (col_pos >= cols) begin
         col_pos = 0; block_col = 0; row_pos++; band_row++;
         if (band_row >= factor) band_row = 0;
      end
      if (row_pos >= rows) begin
         row_pos = 0; band_row = 0;
      end
      if (row_pos == 0 && col_pos == 0) begin
         int unsigned qr, qc;
         qr = rows / tr; qc = cols / tc;
         if (qr == 0) qr = 1;
         if (qc == 0) qc = 1;
         factor = (qr > qc) ? qr : qc;
         if (rows / factor > tr) factor++;
         if (cols / factor > tc) factor++;
         band_row = 0; block_col = 0;
      end
      nr = rows / factor; nc = cols / factor;
      br = row_pos / factor; bc = col_pos / factor;
      p = raw;
      if (m_kind == PIX_UNSIGNED8) begin
         v = longint'(p[7:0]);
      end else begin
         if (m_mask != 0) begin
            if (m_and == MASK_AND) p = p & m_mask;
            else if ((p & m_mask) != 0) p = p | m_mask;
         end
         v = longint'($signed(p));
      end
      if (br < nr && bc < nc) begin
         if (band_row == 0 && block_col == 0) col_sum[bc] = v;
         else col_sum[bc] += v;
         if (band_row == factor - 1 && block_col == factor - 1) begin
            avg.avg_pixel = 16'(col_sum[bc] / (longint'(factor) * longint'(factor)));
            avg.out_rows = 11'(nr);
            avg.out_cols = 11'(nc);
            avg.frame_end = (br == nr - 1 && bc == nc - 1);
            hit = 1;
         end
      end
      col_pos++; block_col++;
      if (block_col >= factor) block_col = 0;
      if (col_pos >= cols) begin
         col_pos = 0; block_col = 0; row_pos++; band_row++;
         if (band_row >= factor) band_row = 0;
         if (row_pos >= rows) begin
            row_pos = 0; band_row = 0;
         end
      end
      return hit;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result side: check each transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         block_avg_type w;
         results++;
         if (pending_avgs.size() == 0) begin
            report_mismatch("unexpected average", rsp_avg_pixel, 0);
         end else begin
            w = pending_avgs.pop_front();
            if (rsp_avg_pixel !== w.avg_pixel)
               report_mismatch("avg_pixel", rsp_avg_pixel, w.avg_pixel);
            if (rsp_out_rows !== w.out_rows)
               report_mismatch("out_rows", rsp_out_rows, w.out_rows);
            if (rsp_out_cols !== w.out_cols)
               report_mismatch("out_cols", rsp_out_cols, w.out_cols);
            if (rsp_frame_end !== w.frame_end)
               report_mismatch("frame_end", rsp_frame_end, w.frame_end);
         end
      end
   end

   // receiver stalls in bursts, or a long hold when asked
   int stall_left = 0;
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         bxavg_pkg::CSR_IMAGE_ROWS:  m_rows = value[10:0];
         bxavg_pkg::CSR_IMAGE_COLS:  m_cols = value[10:0];
         bxavg_pkg::CSR_TARGET_ROWS: m_trows = value[10:0];
         bxavg_pkg::CSR_TARGET_COLS: m_tcols = value[10:0];
         bxavg_pkg::CSR_PIXEL_KIND:  m_kind = value[0];
         bxavg_pkg::CSR_BIT_MASK:    m_mask = value;
         bxavg_pkg::CSR_AND_MODE:    m_and = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      wait (pending_avgs.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one pixel transfer; typed rows replace the predicted average
   task automatic send_pixel(logic [15:0] p, bit typed, block_avg_type want);
      block_avg_type avg;
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (!req_ready);
      items++;
      if (box_filter(p, avg)) pending_avgs.push_back(typed ? want : avg);
   endtask

   task automatic end_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   stim_row_type directed[$];

   function automatic void add_csr(logic [2:0] idx, logic [15:0] value);
      stim_row_type r;
      r.is_csr = 1; r.typed = 0; r.idx = idx; r.value = value; r.want = '0;
      directed.push_back(r);
   endfunction

   function automatic void add_px(logic [15:0] p, bit typed = 0,
                                  block_avg_type want = '0);
      stim_row_type r;
      r.is_csr = 0; r.typed = typed; r.idx = '0; r.value = p; r.want = want;
      directed.push_back(r);
   endfunction

   function automatic void add_block(logic [15:0] p, logic signed [15:0] a);
      add_px(p); add_px(p); add_px(p);
      add_px(p, 1, '{a, 11'd1, 11'd1, 1'b1});
   endfunction

   function automatic void build_table();
      // 2x2 image to one pixel, factor 2
      add_csr(bxavg_pkg::CSR_IMAGE_ROWS, 16'd2);
      add_csr(bxavg_pkg::CSR_IMAGE_COLS, 16'd2);
      add_csr(bxavg_pkg::CSR_TARGET_ROWS, 16'd1);
      add_csr(bxavg_pkg::CSR_TARGET_COLS, 16'd1);
      add_csr(bxavg_pkg::CSR_PIXEL_KIND, 16'(PIX_SIGNED16));
      add_csr(bxavg_pkg::CSR_BIT_MASK, 16'h0000);
      add_csr(bxavg_pkg::CSR_AND_MODE, 16'(MASK_OR));
      add_block(16'h7FFF, 16'sh7FFF);
      add_block(16'h8000, -16'sd32768);
      // sum of -1 truncates toward zero
      add_px(16'd1); add_px(16'hFFFE); add_px(16'd0);
      add_px(16'd0, 1, '{16'sd0, 11'd1, 11'd1, 1'b1});
      add_csr(bxavg_pkg::CSR_PIXEL_KIND, 16'(PIX_UNSIGNED8));
      add_block(16'hFFFF, 16'sd255);
      add_csr(bxavg_pkg::CSR_PIXEL_KIND, 16'(PIX_SIGNED16));
      add_csr(bxavg_pkg::CSR_BIT_MASK, 16'h80F0);
      add_csr(bxavg_pkg::CSR_AND_MODE, 16'(MASK_AND));
      add_px(16'h1234); add_px(16'hFFFF); add_px(16'h000F); add_px(16'h8001);
      add_csr(bxavg_pkg::CSR_AND_MODE, 16'(MASK_OR));
      add_px(16'h1234); add_px(16'h000F); add_px(16'h0080); add_px(16'h7F0F);
      // zero sizes read as one: 1x3 image gives no whole block
      add_csr(bxavg_pkg::CSR_IMAGE_ROWS, 16'd0);
      add_csr(bxavg_pkg::CSR_IMAGE_COLS, 16'd3);
      add_csr(bxavg_pkg::CSR_TARGET_ROWS, 16'd0);
      add_csr(bxavg_pkg::CSR_TARGET_COLS, 16'd0);
      add_px(16'h0001); add_px(16'h0002); add_px(16'h0003);
      // oversize registers clamp; overwritten before any pixel
      add_csr(bxavg_pkg::CSR_IMAGE_ROWS, 16'h07FF);
      add_csr(bxavg_pkg::CSR_IMAGE_COLS, 16'h07FF);
      add_csr(bxavg_pkg::CSR_TARGET_ROWS, 16'd1024);
      add_csr(bxavg_pkg::CSR_TARGET_COLS, 16'd1024);
      add_csr(bxavg_pkg::CSR_BIT_MASK, 16'hFFFF);
   endfunction

   initial begin
      #20ms;
      $display("box_average_image_downscale regression: fail");
      $finish;
   end

   initial begin
      bit last_px;
      int frames, rows, cols, n;
      regs_reset();
      build_table();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      last_px = 0;
      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            if (last_px) begin
               end_pixels();
               wait_drained();
            end
            last_px = 0;
            csr_write(directed[i].idx, directed[i].value);
         end else begin
            last_px = 1;
            send_pixel(directed[i].value, directed[i].typed, directed[i].want);
         end
      end
      end_pixels();
      wait_drained();

      while (items < TARGET_ITEMS) begin
         phases++;
         if (items > 900) quiet = 1;
         if (phases == 3) begin
            rows = 8; cols = 8;
            csr_write(bxavg_pkg::CSR_TARGET_ROWS, 16'd8);
            csr_write(bxavg_pkg::CSR_TARGET_COLS, 16'd8);
         end else begin
            rows = $urandom_range(1, 12);
            cols = $urandom_range(1, 12);
            case ($urandom_range(0, 5))
               0: csr_write(bxavg_pkg::CSR_TARGET_ROWS, 16'd1024);
               1: csr_write(bxavg_pkg::CSR_TARGET_ROWS, 16'd2047);
               default: csr_write(bxavg_pkg::CSR_TARGET_ROWS,
                                  16'($urandom_range(1, 6)));
            endcase
            case ($urandom_range(0, 5))
               0: csr_write(bxavg_pkg::CSR_TARGET_COLS, 16'd1);
               1: csr_write(bxavg_pkg::CSR_TARGET_COLS, 16'd1024);
               default: csr_write(bxavg_pkg::CSR_TARGET_COLS,
                                  16'($urandom_range(1, 6)));
            endcase
         end
         csr_write(bxavg_pkg::CSR_IMAGE_ROWS, 16'(rows));
         csr_write(bxavg_pkg::CSR_IMAGE_COLS, 16'(cols));
         csr_write(bxavg_pkg::CSR_PIXEL_KIND,
                   ($urandom_range(0, 3) == 0) ? 16'(PIX_UNSIGNED8) : 16'(PIX_SIGNED16));
         csr_write(bxavg_pkg::CSR_BIT_MASK,
                   ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
         csr_write(bxavg_pkg::CSR_AND_MODE, 16'($urandom_range(0, 1)));
         frames = $urandom_range(1, 3);
         if (phases == 3) begin
            // long receiver hold while pixels keep coming
            fork
               begin
                  hold_rsp = 1;
                  repeat (500) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         n = frames * rows * cols;
         repeat (n) send_pixel(rand_pixel(), 0, '0);
         end_pixels();
         wait_drained();
      end

      $display("covered %0d pixels in %0d random phases plus the directed table",
               items, phases);
      $display("%0d block averages compared, %0d mismatches", results, errors);
      if (errors == 0)
         $display("box_average_image_downscale regression: pass");
      else
         $display("box_average_image_downscale regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bxavg_pkg.sv
hdl/bxavg_div.sv
hdl/bxavg_datapath.sv
hdl/bxavg_ctrl.sv
hdl/box_average_image_downscale.sv
tb/testbench.sv
